// File: hdl/slpc_pkg.sv
// shared types, constants and look tables of the status led controller
`timescale 1ns / 1ps
package slpc_pkg;

    localparam int unsigned TimeW = 32;

    typedef struct packed {
        logic [23:0] color;
        logic [23:0] color2;
        logic [2:0]  pattern;
    } look_t;

    localparam logic [2:0] FUNC_INIT     = 3'd0;
    localparam logic [2:0] FUNC_STATE    = 3'd1;
    localparam logic [2:0] FUNC_OVERRIDE = 3'd2;
    localparam logic [2:0] FUNC_FEEDBACK = 3'd3;
    localparam logic [2:0] FUNC_UPDATE   = 3'd4;

    localparam logic [2:0] PTN_STEADY   = 3'd1;
    localparam logic [2:0] PTN_SLOW     = 3'd2;
    localparam logic [2:0] PTN_FAST     = 3'd3;
    localparam logic [2:0] PTN_FADE     = 3'd4;
    localparam logic [2:0] PTN_ALT      = 3'd5;
    localparam logic [2:0] PTN_LAMPTEST = 3'd6;

    localparam logic [1:0] FB_ACCEPTED = 2'd0;
    localparam logic [1:0] FB_REJECTED = 2'd1;
    localparam logic [1:0] FB_IGNORED  = 2'd2;
    localparam logic [1:0] FB_NONE     = 2'd3;

    localparam logic [3:0] NUM_STATES    = 4'd13;
    localparam logic [2:0] PAT_REQ_LIMIT = 3'd5;
    localparam logic [2:0] NUM_OVR       = 3'd6;
    localparam logic [2:0] OVR_ESTOP     = 3'd3;

    localparam logic [23:0] C_OFF    = 24'h000000;
    localparam logic [23:0] C_RED    = 24'hFF0000;
    localparam logic [23:0] C_GREEN  = 24'h00FF00;
    localparam logic [23:0] C_BLUE   = 24'h0000FF;
    localparam logic [23:0] C_WHITE  = 24'hFFFFFF;
    localparam logic [23:0] C_PURPLE = 24'hFF00FF;
    localparam logic [23:0] C_AMBER  = 24'hFF6E00;
    localparam logic [23:0] C_CYAN   = 24'h00FFFF;

    localparam logic [31:0] SELFTEST_TOTAL_MS = 32'd900;

    function automatic look_t state_look(input logic [3:0] idx);
        look_t lk;
        lk.color2 = C_OFF;
        case (idx)
            4'd0:    begin lk.color = C_GREEN;  lk.pattern = PTN_STEADY; end
            4'd1:    begin lk.color = C_BLUE;   lk.pattern = PTN_STEADY; end
            4'd2:    begin lk.color = C_GREEN;  lk.pattern = PTN_SLOW;   end
            4'd3:    begin lk.color = C_RED;    lk.pattern = PTN_STEADY; end
            4'd4:    begin lk.color = C_PURPLE; lk.pattern = PTN_STEADY; end
            4'd5:    begin lk.color = C_RED;    lk.pattern = PTN_FAST;   end
            4'd6:    begin lk.color = C_CYAN;   lk.pattern = PTN_SLOW;   end
            4'd7:    begin lk.color = C_WHITE;  lk.pattern = PTN_FADE;   end
            4'd8:    begin lk.color = C_BLUE;   lk.pattern = PTN_FAST;   end
            4'd9:    begin lk.color = C_WHITE;  lk.pattern = PTN_STEADY; end
            4'd10:   begin lk.color = C_WHITE;  lk.pattern = PTN_SLOW;   end
            4'd11:   begin lk.color = C_AMBER;  lk.pattern = PTN_STEADY; end
            default: begin lk.color = C_AMBER;  lk.pattern = PTN_SLOW;   end
        endcase
        return lk;
    endfunction

    function automatic look_t ovr_look(input logic [2:0] idx);
        look_t lk;
        lk.color2 = C_OFF;
        case (idx)
            3'd0:    begin lk.color = C_OFF;  lk.pattern = PTN_LAMPTEST; end
            3'd1:    begin lk.color = C_RED;  lk.color2 = C_BLUE; lk.pattern = PTN_ALT; end
            3'd2:    begin lk.color = C_CYAN; lk.pattern = PTN_SLOW;     end
            3'd3:    begin lk.color = C_RED;  lk.pattern = PTN_FAST;     end
            3'd4:    begin lk.color = C_RED;  lk.pattern = PTN_STEADY;   end
            default: begin lk.color = C_RED;  lk.pattern = PTN_SLOW;     end
        endcase
        return lk;
    endfunction

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [11:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [11:0] rem;
    } div_rsp_t;

endpackage

// File: hdl/slpc_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module slpc_divider
    import slpc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [31:0] quot_reg, quot_next;
    logic [11:0] rem_reg, rem_next;
    logic [11:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [12:0] trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[31]} - {1'b0, dvs_reg};
        if (req.start) begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[12]) begin
                rem_next = {rem_reg[10:0], quot_reg[31]};
                quot_next = {quot_reg[30:0], 1'b0};
            end else begin
                rem_next = trial[11:0];
                quot_next = {quot_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

// File: hdl/slpc_mult.sv
// shift-add multiplier, 12 by 12 bits, one multiplier bit per cycle
`timescale 1ns / 1ps
module slpc_mult
    import slpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [11:0] a,
    input  logic [11:0] b,
    output logic        done,
    output logic [23:0] prod
);

    logic [23:0] acc_reg, acc_next;
    logic [23:0] mcd_reg, mcd_next;
    logic [11:0] mpl_reg, mpl_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb begin
        acc_next  = acc_reg;
        mcd_next  = mcd_reg;
        mpl_next  = mpl_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            mcd_next  = {12'd0, a};
            mpl_next  = b;
            cnt_next  = 4'd12;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (mpl_reg[0]) acc_next = acc_reg + mcd_reg;
            mcd_next = {mcd_reg[22:0], 1'b0};
            mpl_next = {1'b0, mpl_reg[11:1]};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        mcd_reg <= mcd_next;
        mpl_reg <= mpl_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: hdl/status_led_pattern_controller.sv
// top level of the rgb status led controller: state, sequencer and output register
//
//  channel | ports    | tuser | tdata fields (low bit first)
//  input   | s_axis_* | func  | now_ms, state_sel, pattern_req, override_id, override_on,
//          |          |       | feedback_kind (45 bits in 48)
//  result  | m_axis_* | -     | red, green, blue, status (25 bits in 32)
//
// init, set-state, override and feedback beats: result registered via ST_EXEC and ST_OUT
// update beats run ST_FLASH, ST_PICK and ST_OUT when nothing is shown; a flash, a plain
// pattern and breathe also wait on the 32-step serial divider (flash remainder,
// pattern remainder, breathe level), and breathe on the 12-step serial multiplier
// reset equals init at time 0 with every look cleared; no clearing pass
// the input is stalled while a beat is in work or its result is not yet taken
`timescale 1ns / 1ps
module status_led_pattern_controller
    import slpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[2:0]
    input  logic [2:0]  s_axis_tuser,
    // now_ms[31:0] state_sel[35:32] pattern_req[38:36] override_id[41:39]
    // override_on[42] feedback_kind[44:43]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red[7:0] green[15:8] blue[23:16] status[24]
    output logic [31:0] m_axis_tdata
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_EXEC   = 10'b0000000010,
        ST_FLASH  = 10'b0000000100,
        ST_FWAIT  = 10'b0000001000,
        ST_PICK   = 10'b0000010000,
        ST_PWAIT  = 10'b0000100000,
        ST_SQR    = 10'b0001000000,
        ST_SWAIT  = 10'b0010000000,
        ST_BWAIT  = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [47:0] in_reg;
    logic [5:0]  flags_reg, flags_next;
    logic [31:0] st_start_reg, st_start_next;
    logic        cmd_ok_reg, cmd_ok_next;
    look_t       cmd_look_reg, cmd_look_next;
    logic        hold_reg, hold_next;
    look_t       hold_look_reg, hold_look_next;
    logic        fl_act_reg, fl_act_next;
    logic [23:0] fl_color_reg, fl_color_next;
    logic [1:0]  fl_cnt_reg, fl_cnt_next;
    logic [31:0] fl_start_reg, fl_start_next;
    look_t       shown_reg, shown_next;
    logic        shown_ok_reg, shown_ok_next;
    logic [31:0] phase_reg, phase_next;
    logic [23:0] rgb_reg, rgb_next;
    logic        status_reg, status_next;
    logic        mv_reg, mv_next;
    logic [11:0] tri_reg, tri_next;

    logic [2:0]  f_func;
    logic [31:0] f_now;
    logic [3:0]  f_st;
    logic [2:0]  f_pat;
    logic [2:0]  f_id;
    logic        f_on;
    logic [1:0]  f_fb;

    div_req_t    dreq;
    div_rsp_t    drsp;
    logic        m_start, m_done;
    logic [11:0] m_a;
    logic [23:0] m_prod;

    logic [31:0] tflash;
    logic [9:0]  flash_len;
    logic        any_ovr;
    logic [2:0]  ovr_idx;
    logic        have_look;
    look_t       win;
    logic [31:0] phase_use;
    logic [7:0]  lvl;

    assign f_func = in_reg[2:0];
    assign f_now  = in_reg[34:3];
    assign f_st   = in_reg[38:35];
    assign f_pat  = in_reg[41:39];
    assign f_id   = in_reg[44:42];
    assign f_on   = in_reg[45];
    assign f_fb   = in_reg[47:46];

    slpc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    slpc_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (m_start),
        .a       (m_a),
        .b       (m_a),
        .done    (m_done),
        .prod    (m_prod)
    );

    assign tflash    = f_now - fl_start_reg;
    assign flash_len = {fl_cnt_reg, 8'd0} + {3'd0, fl_cnt_reg, 5'd0}
                     + {5'd0, fl_cnt_reg, 3'd0} + {6'd0, fl_cnt_reg, 2'd0};
    assign m_a = tri_reg;

    always_comb begin
        any_ovr = |flags_reg;
        ovr_idx = 3'd5;
        for (int i = 5; i >= 0; i--) begin
            if (flags_reg[i]) ovr_idx = 3'(i);
        end
        have_look = 1'b1;
        if (any_ovr) win = ovr_look(ovr_idx);
        else if (hold_reg) win = hold_look_reg;
        else if (cmd_ok_reg) win = cmd_look_reg;
        else begin
            win = '0;
            have_look = 1'b0;
        end
    end

    assign phase_use = (!shown_ok_reg || win != shown_reg)
                     ? ((any_ovr && ovr_idx == 3'd0) ? st_start_reg : f_now) : phase_reg;
    assign lvl = drsp.quot[7:0];

    always_comb begin
        state_next     = state_reg;
        flags_next     = flags_reg;
        st_start_next  = st_start_reg;
        cmd_ok_next    = cmd_ok_reg;
        cmd_look_next  = cmd_look_reg;
        hold_next      = hold_reg;
        hold_look_next = hold_look_reg;
        fl_act_next    = fl_act_reg;
        fl_color_next  = fl_color_reg;
        fl_cnt_next    = fl_cnt_reg;
        fl_start_next  = fl_start_reg;
        shown_next     = shown_reg;
        shown_ok_next  = shown_ok_reg;
        phase_next     = phase_reg;
        rgb_next       = rgb_reg;
        status_next    = status_reg;
        mv_next        = mv_reg;
        tri_next       = tri_reg;
        dreq           = '0;
        m_start        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                rgb_next    = C_OFF;
                status_next = 1'b0;
                state_next  = ST_OUT;
                case (f_func)
                    FUNC_INIT: begin
                        flags_next    = 6'b000001;
                        st_start_next = f_now;
                        cmd_ok_next   = 1'b0;
                        hold_next     = 1'b0;
                        fl_act_next   = 1'b0;
                        shown_ok_next = 1'b0;
                    end
                    FUNC_STATE: begin
                        if (f_st >= NUM_STATES || f_pat >= PAT_REQ_LIMIT) begin
                            status_next = 1'b1;
                        end else begin
                            cmd_look_next = state_look(f_st);
                            if (f_pat != 3'd0) cmd_look_next.pattern = f_pat;
                            cmd_ok_next = 1'b1;
                            hold_next   = 1'b0;
                        end
                    end
                    FUNC_OVERRIDE: begin
                        if (f_id < NUM_OVR && flags_reg[f_id] != f_on) begin
                            flags_next[f_id] = f_on;
                            if (f_on) begin
                                fl_act_next = 1'b0;
                            end else if (f_id >= OVR_ESTOP) begin
                                hold_look_next = ovr_look(f_id);
                                hold_next      = 1'b1;
                                cmd_ok_next    = 1'b0;
                            end
                        end
                    end
                    FUNC_FEEDBACK: begin
                        if (!any_ovr && !hold_reg && cmd_ok_reg && f_fb != FB_NONE) begin
                            if (f_fb == FB_ACCEPTED) begin
                                fl_color_next = C_GREEN;
                                fl_cnt_next   = 2'd2;
                            end else if (f_fb == FB_REJECTED) begin
                                fl_color_next = C_RED;
                                fl_cnt_next   = 2'd3;
                            end else begin
                                fl_color_next = C_RED;
                                fl_cnt_next   = 2'd1;
                            end
                            fl_start_next = f_now;
                            fl_act_next   = 1'b1;
                        end
                    end
                    FUNC_UPDATE: begin
                        if (flags_reg[0] && (f_now - st_start_reg) >= SELFTEST_TOTAL_MS)
                            flags_next[0] = 1'b0;
                        state_next = ST_FLASH;
                    end
                    default: ;
                endcase
            end
            ST_FLASH: begin
                if (fl_act_reg && tflash < {22'd0, flash_len}) begin
                    dreq.start    = 1'b1;
                    dreq.dividend = tflash;
                    dreq.divisor  = 12'd300;
                    shown_ok_next = 1'b0;
                    state_next    = ST_FWAIT;
                end else begin
                    fl_act_next = 1'b0;
                    state_next  = ST_PICK;
                end
            end
            ST_FWAIT: begin
                if (drsp.done) begin
                    rgb_next   = (drsp.rem < 12'd150) ? fl_color_reg : C_OFF;
                    state_next = ST_OUT;
                end
            end
            ST_PICK: begin
                if (!have_look) begin
                    shown_ok_next = 1'b0;
                    state_next    = ST_OUT;
                end else begin
                    shown_next    = win;
                    shown_ok_next = 1'b1;
                    phase_next    = phase_use;
                    dreq.start    = 1'b1;
                    dreq.dividend = f_now - phase_use;
                    case (win.pattern)
                        PTN_FAST:     dreq.divisor = 12'd250;
                        PTN_FADE:     dreq.divisor = 12'd2000;
                        PTN_LAMPTEST: dreq.divisor = 12'd300;
                        default:      dreq.divisor = 12'd1000;
                    endcase
                    state_next = ST_PWAIT;
                end
            end
            ST_PWAIT: begin
                if (drsp.done) begin
                    state_next = ST_OUT;
                    case (shown_reg.pattern)
                        PTN_STEADY: rgb_next = shown_reg.color;
                        PTN_SLOW:   rgb_next = (drsp.rem < 12'd500) ? shown_reg.color : C_OFF;
                        PTN_FAST:   rgb_next = (drsp.rem < 12'd125) ? shown_reg.color : C_OFF;
                        PTN_ALT:    rgb_next = (drsp.rem < 12'd500) ? shown_reg.color
                                                                    : shown_reg.color2;
                        PTN_LAMPTEST: begin
                            if (drsp.quot == 32'd0) rgb_next = C_RED;
                            else if (drsp.quot == 32'd1) rgb_next = C_GREEN;
                            else if (drsp.quot == 32'd2) rgb_next = C_BLUE;
                            else rgb_next = C_OFF;
                        end
                        PTN_FADE: begin
                            tri_next   = (drsp.rem < 12'd1000) ? 12'd1000 - drsp.rem
                                                               : drsp.rem - 12'd1000;
                            state_next = ST_SQR;
                        end
                        default: rgb_next = C_OFF;
                    endcase
                end
            end
            ST_SQR: begin
                m_start    = 1'b1;
                state_next = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (m_done) begin
                    dreq.start    = 1'b1;
                    dreq.dividend = {8'd0, m_prod};
                    dreq.divisor  = 12'd3907;
                    state_next    = ST_BWAIT;
                end
            end
            ST_BWAIT: begin
                if (drsp.done) begin
                    rgb_next[23:16] = 8'(({8'd0, shown_reg.color[23:16]} * {8'd0, lvl}) >> 8);
                    rgb_next[15:8]  = 8'(({8'd0, shown_reg.color[15:8]} * {8'd0, lvl}) >> 8);
                    rgb_next[7:0]   = 8'(({8'd0, shown_reg.color[7:0]} * {8'd0, lvl}) >> 8);
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                mv_next = 1'b1;
                if (mv_reg && m_axis_tready) begin
                    mv_next    = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_axis_tvalid) in_reg <= {s_axis_tdata[44:0], s_axis_tuser};
        rgb_reg    <= rgb_next;
        status_reg <= status_next;
        tri_reg    <= tri_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            flags_reg     <= 6'b000001;
            st_start_reg  <= '0;
            cmd_ok_reg    <= 1'b0;
            cmd_look_reg  <= '0;
            hold_reg      <= 1'b0;
            hold_look_reg <= '0;
            fl_act_reg    <= 1'b0;
            fl_color_reg  <= '0;
            fl_cnt_reg    <= '0;
            fl_start_reg  <= '0;
            shown_reg     <= '0;
            shown_ok_reg  <= 1'b0;
            phase_reg     <= '0;
            mv_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            flags_reg     <= flags_next;
            st_start_reg  <= st_start_next;
            cmd_ok_reg    <= cmd_ok_next;
            cmd_look_reg  <= cmd_look_next;
            hold_reg      <= hold_next;
            hold_look_reg <= hold_look_next;
            fl_act_reg    <= fl_act_next;
            fl_color_reg  <= fl_color_next;
            fl_cnt_reg    <= fl_cnt_next;
            fl_start_reg  <= fl_start_next;
            shown_reg     <= shown_next;
            shown_ok_reg  <= shown_ok_next;
            phase_reg     <= phase_next;
            mv_reg        <= mv_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = {7'd0, status_reg, rgb_reg[7:0], rgb_reg[15:8], rgb_reg[23:16]};

endmodule

// File: test/tb_top.sv
// self-checking testbench of the status led controller: driven beats, predicted colors
`timescale 1ns / 1ps
module tb_top;
    import slpc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser = '0;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    status_led_pattern_controller i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predicted controller state
    logic [5:0]  ovr_flags;
    logic [31:0] st_start;
    logic        cmd_ok, hold_ok, fl_on, shown_ok;
    look_t       cmd_look, hold_look, shown_look;
    logic [23:0] fl_color;
    logic [1:0]  fl_cnt;
    logic [31:0] fl_start, ph_start;

    logic [47:0] beat_q[$];
    logic [31:0] color_q[$];
    int          errors = 0, n_sent = 0, n_got = 0, n_upd = 0;
    int          in_gap = 0, out_gap = 0;
    bit          stim_done = 1'b0;
    longint      cycles = 0;
    logic [31:0] clock_ms = 0;

    function automatic logic [23:0] pattern_color(look_t lk, logic [31:0] t);
        logic [31:0] p, tri_v, lvl;
        case (lk.pattern)
            PTN_STEADY: return lk.color;
            PTN_SLOW:   return (t % 1000) < 500 ? lk.color : C_OFF;
            PTN_FAST:   return (t % 250) < 125 ? lk.color : C_OFF;
            PTN_FADE: begin
                p = t % 2000;
                tri_v = p < 1000 ? 1000 - p : p - 1000;
                lvl = tri_v * tri_v / 3907;
                return {8'((lk.color[23:16] * lvl) >> 8), 8'((lk.color[15:8] * lvl) >> 8),
                        8'((lk.color[7:0] * lvl) >> 8)};
            end
            PTN_ALT:    return (t % 1000) < 500 ? lk.color : lk.color2;
            PTN_LAMPTEST: begin
                p = t / 300;
                if (p == 0) return C_RED;
                if (p == 1) return C_GREEN;
                if (p == 2) return C_BLUE;
                return C_OFF;
            end
            default:    return C_OFF;
        endcase
    endfunction

    function automatic void led_init(logic [31:0] now);
        ovr_flags = 6'b000001;
        st_start = now;
        cmd_ok = 0; hold_ok = 0; fl_on = 0; shown_ok = 0;
    endfunction

    function automatic logic [23:0] led_update(logic [31:0] now);
        logic [31:0] t;
        look_t lk;
        int w;
        bit found;
        w = -1;
        found = 0;
        if (ovr_flags[0] && (now - st_start) >= 900) ovr_flags[0] = 1'b0;
        if (fl_on) begin
            t = now - fl_start;
            if (t < fl_cnt * 300) begin
                shown_ok = 0;
                return (t % 300) < 150 ? fl_color : C_OFF;
            end
            fl_on = 0;
        end
        for (int i = 5; i >= 0; i--) if (ovr_flags[i]) w = i;
        if (w >= 0) begin lk = ovr_look(3'(w)); found = 1; end
        else if (hold_ok) begin lk = hold_look; found = 1; end
        else if (cmd_ok) begin lk = cmd_look; found = 1; end
        if (!found) begin
            shown_ok = 0;
            return C_OFF;
        end
        if (!shown_ok || lk != shown_look) begin
            shown_look = lk;
            shown_ok = 1;
            ph_start = (w == 0) ? st_start : now;
        end
        return pattern_color(lk, now - ph_start);
    endfunction

    function automatic logic [31:0] led_step(logic [47:0] d);
        logic [2:0]  fn, pat, id;
        logic [31:0] now;
        logic [3:0]  st;
        logic        on;
        logic [1:0]  fb;
        logic [23:0] rgb;
        logic        status;
        fn = d[2:0]; now = d[34:3]; st = d[38:35]; pat = d[41:39];
        id = d[44:42]; on = d[45]; fb = d[47:46];
        rgb = C_OFF;
        status = 0;
        case (fn)
            FUNC_INIT: led_init(now);
            FUNC_STATE:
                if (st >= NUM_STATES || pat >= PAT_REQ_LIMIT) status = 1;
                else begin
                    cmd_look = state_look(st);
                    if (pat != 0) cmd_look.pattern = pat;
                    cmd_ok = 1; hold_ok = 0;
                end
            FUNC_OVERRIDE:
                if (id < NUM_OVR && ovr_flags[id] != on) begin
                    ovr_flags[id] = on;
                    if (on) fl_on = 0;
                    else if (id >= OVR_ESTOP) begin
                        hold_look = ovr_look(id); hold_ok = 1; cmd_ok = 0;
                    end
                end
            FUNC_FEEDBACK:
                if (ovr_flags == 0 && !hold_ok && cmd_ok && fb != FB_NONE) begin
                    fl_color = fb == FB_ACCEPTED ? C_GREEN : C_RED;
                    fl_cnt = fb == FB_ACCEPTED ? 2'd2 : fb == FB_REJECTED ? 2'd3 : 2'd1;
                    fl_start = now;
                    fl_on = 1;
                end
            FUNC_UPDATE: rgb = led_update(now);
            default: ;
        endcase
        return {7'd0, status, rgb[7:0], rgb[15:8], rgb[23:16]};
    endfunction

    function automatic logic [47:0] mk_beat(logic [2:0] fn, logic [31:0] now,
            logic [3:0] st = 0, logic [2:0] pat = 0, logic [2:0] id = 0,
            logic on = 0, logic [1:0] fb = 0);
        return {fb, on, id, pat, st, now, fn};
    endfunction

    task automatic push(logic [47:0] d);
        beat_q.push_back(d);
    endtask

    // time moves forward mostly in small steps, with rare jumps and wraps
    function automatic logic [31:0] tick();
        int r;
        r = $urandom_range(99);
        if (r < 80) clock_ms += $urandom_range(60);
        else if (r < 97) clock_ms += $urandom_range(1500);
        else clock_ms = $urandom;
        return clock_ms;
    endfunction

    // idle gaps: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(80, 20);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    // driver
    always @(posedge aclk) begin
        logic [47:0] nb;
        cycles++;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                color_q.push_back(led_step({s_axis_tdata[44:0], s_axis_tuser}));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (beat_q.size() > 0) begin
                    nb = beat_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nb[2:0];
                    s_axis_tdata  <= {3'd0, nb[47:3]};
                    in_gap = pick_gap();
                end else
                    s_axis_tvalid <= 1'b0;
            end
            if (out_gap > 0) begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                out_gap = pick_gap();
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_got++;
            if (color_q.size() == 0) report("unexpected beat", m_axis_tdata, 0);
            else begin
                want = color_q.pop_front();
                if (m_axis_tdata[7:0] != want[7:0]) report("red", m_axis_tdata[7:0], want[7:0]);
                if (m_axis_tdata[15:8] != want[15:8])
                    report("green", m_axis_tdata[15:8], want[15:8]);
                if (m_axis_tdata[23:16] != want[23:16])
                    report("blue", m_axis_tdata[23:16], want[23:16]);
                if (m_axis_tdata[24] != want[24]) report("status", m_axis_tdata[24], want[24]);
            end
        end
    end

    initial begin
        int r;
        logic [31:0] now;
        cmd_look = '0; hold_look = '0; shown_look = '0;
        fl_color = 0; fl_cnt = 0; fl_start = 0; ph_start = 0;
        led_init(0);
        // directed
        push(mk_beat(FUNC_UPDATE, 32'd0));
        push(mk_beat(FUNC_UPDATE, 32'd450));
        push(mk_beat(FUNC_UPDATE, 32'd899));
        push(mk_beat(FUNC_STATE, 32'hFFFFFFFF, 4'd15, 3'd7, 3'd7, 1'b1, FB_NONE));
        push(mk_beat(FUNC_STATE, 0, 4'd0, 3'd5));
        push(mk_beat(FUNC_STATE, 0, 4'd7, 3'd0));
        push(mk_beat(FUNC_UPDATE, 32'd1000));
        push(mk_beat(FUNC_UPDATE, 32'd1500));
        push(mk_beat(FUNC_FEEDBACK, 32'd1600, 0, 0, 0, 0, FB_REJECTED));
        push(mk_beat(FUNC_UPDATE, 32'd1700));
        push(mk_beat(FUNC_UPDATE, 32'd2600));
        push(mk_beat(FUNC_OVERRIDE, 0, 0, 0, 3'd1, 1'b1));
        push(mk_beat(FUNC_UPDATE, 32'd3200));
        push(mk_beat(FUNC_OVERRIDE, 0, 0, 0, 3'd7, 1'b1));
        push(mk_beat(FUNC_OVERRIDE, 0, 0, 0, 3'd1, 1'b0));
        push(mk_beat(FUNC_OVERRIDE, 0, 0, 0, 3'd3, 1'b1));
        push(mk_beat(FUNC_OVERRIDE, 0, 0, 0, 3'd3, 1'b0));
        push(mk_beat(FUNC_FEEDBACK, 32'd3300, 0, 0, 0, 0, FB_ACCEPTED));
        push(mk_beat(FUNC_UPDATE, 32'd3400));
        push(mk_beat(3'd7, 32'hFFFFFFFF, 4'd15, 3'd7, 3'd7, 1'b1, FB_NONE));
        push(mk_beat(FUNC_STATE, 0, 4'd12, 3'd4));
        push(mk_beat(FUNC_FEEDBACK, 32'hFFFFFF00, 0, 0, 0, 0, FB_IGNORED));
        push(mk_beat(FUNC_UPDATE, 32'h00000010));
        push(mk_beat(FUNC_UPDATE, 32'h00000300));
        clock_ms = 32'h300;
        // random, mostly plausible traffic with many updates
        for (int i = 0; i < 1900; i++) begin
            now = tick();
            r = $urandom_range(99);
            if (r < 50) push(mk_beat(FUNC_UPDATE, now));
            else if (r < 62) push(mk_beat(FUNC_STATE, $urandom,
                     ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(12)),
                     ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(4)),
                     3'($urandom), 1'($urandom), 2'($urandom)));
            else if (r < 72) push(mk_beat(FUNC_OVERRIDE, $urandom, 4'($urandom), 3'($urandom),
                     3'($urandom), $urandom_range(2) == 0, 2'($urandom)));
            else if (r < 90) push(mk_beat(FUNC_FEEDBACK, now, 4'($urandom), 3'($urandom),
                     3'($urandom), 1'($urandom), 2'($urandom)));
            else if (r < 94) push(mk_beat(FUNC_INIT, now));
            else push(mk_beat(3'($urandom), $urandom, 4'($urandom), 3'($urandom), 3'($urandom),
                     1'($urandom), 2'($urandom)));
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        wait (beat_q.size() == 0 && !s_axis_tvalid);
        wait (color_q.size() == 0);
        repeat (200) @(posedge aclk);
        stim_done = 1'b1;
    end

    always @(posedge aclk) begin
        if (stim_done) begin
            $display("covered %0d beats in, %0d results out, in %0d cycles",
                     n_sent, n_got, cycles);
            if (errors == 0 && color_q.size() == 0) $display("RESULT: OK");
            else $display("RESULT: ERROR");
            $finish;
        end else if (cycles > 3000000) begin
            $display("timeout with %0d results pending", color_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
